@@ hw/rtl/att_pkg.sv @@
package att_pkg;

  localparam int ENTRIES = 64;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int BYTES_W = 38;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    OUT_NULL      = 3'd0,
    OUT_UPDATED   = 3'd1,
    OUT_NEW       = 3'd2,
    OUT_FULL      = 3'd3,
    OUT_RELEASED  = 3'd4,
    OUT_NOT_FOUND = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ADJ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] alloc_size;
  } item_t;

  typedef struct packed {
    outcome_t           outcome;
    logic               accepted;
    logic [6:0]         live_count;
    logic [BYTES_W-1:0] live_bytes;
    logic [BYTES_W-1:0] peak_live_bytes;
    logic [31:0]        dropped_total;
    logic               leaks_present;
  } result_t;

  // query token walking the cell chain
  typedef struct packed {
    logic              act;
    logic              mode;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              matched;
    logic              claimed;
    logic [SIZE_W-1:0] old_size;
  } tok_t;

  // end-of-walk decision broadcast to every cell
  typedef struct packed {
    logic fire;
    logic keep;
  } cmt_t;

endpackage

@@ hw/rtl/att_cell.sv @@
module att_cell
  import att_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  input  cmt_t cmt_i,
  output tok_t tok_o
);

  logic              valid_r, valid_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  tok_t              tok_r, tok_nxt;
  logic              hit, take_free;

  always_comb begin
    hit       = tok_i.act && valid_r && (addr_r == tok_i.addr) && !tok_i.matched;
    take_free = tok_i.act && !valid_r && !pend_r && !tok_i.claimed && !tok_i.matched
                && (tok_i.mode == MODE_ALLOC);
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    addr_nxt  = addr_r;
    size_nxt  = size_r;
    tok_nxt   = tok_i;
    if (hit) begin
      tok_nxt.matched  = 1'b1;
      tok_nxt.old_size = size_r;
      if (tok_i.mode == MODE_ALLOC) begin
        size_nxt = tok_i.size;
      end else begin
        valid_nxt = 1'b0;
      end
    end else if (take_free) begin
      // claim tentatively: a later cell may still hold the address
      tok_nxt.claimed = 1'b1;
      pend_nxt        = 1'b1;
      addr_nxt        = tok_i.addr;
      size_nxt        = tok_i.size;
    end
    if (cmt_i.fire && pend_r) begin
      valid_nxt = cmt_i.keep;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      pend_r      <= 1'b0;
      tok_r.act   <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      tok_r.act   <= tok_nxt.act;
    end
    addr_r           <= addr_nxt;
    size_r           <= size_nxt;
    tok_r.mode       <= tok_nxt.mode;
    tok_r.addr       <= tok_nxt.addr;
    tok_r.size       <= tok_nxt.size;
    tok_r.matched    <= tok_nxt.matched;
    tok_r.claimed    <= tok_nxt.claimed;
    tok_r.old_size   <= tok_nxt.old_size;
  end

  assign tok_o = tok_r;

endmodule

@@ hw/rtl/att_ctrl.sv @@
module att_ctrl
  import att_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data,
  output tok_t    tok_o,
  input  tok_t    tok_i,
  output cmt_t    cmt_o
);

  state_t             state_r, state_nxt;
  logic               mode_r, mode_nxt;
  logic               null_r, null_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               matched_r, matched_nxt;
  logic               claimed_r, claimed_nxt;
  logic [SIZE_W-1:0]  old_r, old_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [BYTES_W-1:0] peak_r, peak_nxt;
  logic [31:0]        drop_r, drop_nxt;
  tok_t               tok_r, tok_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_data_r, out_data_nxt;
  logic               accept, emit, grow;
  logic [BYTES_W:0]   sum;
  logic [BYTES_W-1:0] sat_sum;
  outcome_t           outc;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    null_nxt      = null_r;
    size_nxt      = size_r;
    matched_nxt   = matched_r;
    claimed_nxt   = claimed_r;
    old_nxt       = old_r;
    cnt_nxt       = cnt_r;
    bytes_nxt     = bytes_r;
    peak_nxt      = peak_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tok_nxt       = '0;
    emit          = 1'b0;
    grow          = 1'b0;
    outc          = OUT_NULL;
    cmt_o         = '0;
    sum           = {1'b0, bytes_r} + (BYTES_W+1)'(size_r);
    sat_sum       = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt    = in_data.mode;
          size_nxt    = in_data.alloc_size;
          null_nxt    = (in_data.address == '0);
          matched_nxt = 1'b0;
          claimed_nxt = 1'b0;
          if (in_data.address == '0) begin
            state_nxt = ST_DONE;
          end else begin
            tok_nxt.act  = 1'b1;
            tok_nxt.mode = in_data.mode;
            tok_nxt.addr = in_data.address;
            tok_nxt.size = in_data.alloc_size;
            state_nxt    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (tok_i.act) begin
          matched_nxt = tok_i.matched;
          claimed_nxt = tok_i.claimed;
          old_nxt     = tok_i.old_size;
          state_nxt   = ST_ADJ;
        end
      end
      ST_ADJ: begin
        // take the old size off the total first, floored at zero
        if (matched_r) begin
          bytes_nxt = (bytes_r >= BYTES_W'(old_r)) ? bytes_r - BYTES_W'(old_r) : '0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        emit = !(out_valid_r && out_stall);
        if (null_r) begin
          outc = OUT_NULL;
        end else if (mode_r == MODE_ALLOC) begin
          if (matched_r) begin
            outc = OUT_UPDATED;
            grow = 1'b1;
          end else if (claimed_r) begin
            outc = OUT_NEW;
            grow = 1'b1;
          end else begin
            outc = OUT_FULL;
          end
        end else begin
          outc = matched_r ? OUT_RELEASED : OUT_NOT_FOUND;
        end
        if (emit) begin
          if (grow) begin
            bytes_nxt = sat_sum;
            if (sat_sum > peak_r) begin
              peak_nxt = sat_sum;
            end
          end
          if (outc == OUT_NEW) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (outc == OUT_RELEASED && cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          if (outc == OUT_FULL) begin
            drop_nxt = drop_r + 32'd1;
          end
          cmt_o.fire                   = 1'b1;
          cmt_o.keep                   = !matched_r;
          out_valid_nxt                = 1'b1;
          out_data_nxt.outcome         = outc;
          out_data_nxt.accepted        = (outc == OUT_UPDATED) || (outc == OUT_NEW)
                                         || (outc == OUT_RELEASED);
          out_data_nxt.live_count      = 7'(cnt_nxt);
          out_data_nxt.live_bytes      = bytes_nxt;
          out_data_nxt.peak_live_bytes = peak_nxt;
          out_data_nxt.dropped_total   = drop_nxt;
          out_data_nxt.leaks_present   = (cnt_nxt != '0);
          state_nxt                    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bytes_r     <= '0;
      peak_r      <= '0;
      drop_r      <= '0;
      tok_r.act   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      peak_r      <= peak_nxt;
      drop_r      <= drop_nxt;
      tok_r.act   <= tok_nxt.act;
      out_valid_r <= out_valid_nxt;
    end
    mode_r         <= mode_nxt;
    null_r         <= null_nxt;
    size_r         <= size_nxt;
    matched_r      <= matched_nxt;
    claimed_r      <= claimed_nxt;
    old_r          <= old_nxt;
    tok_r.mode     <= tok_nxt.mode;
    tok_r.addr     <= tok_nxt.addr;
    tok_r.size     <= tok_nxt.size;
    tok_r.matched  <= tok_nxt.matched;
    tok_r.claimed  <= tok_nxt.claimed;
    tok_r.old_size <= tok_nxt.old_size;
    out_data_r     <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tok_o     = tok_r;

endmodule

@@ hw/rtl/allocation_tracking_table_unit.sv @@
// An accepted beat's token leaves a controller register and steps one table cell per
// cycle along the chain; the controller then passes its walk, adjust and done states
// and writes the output register. A null address skips the walk. No new beat is taken
// until the result is written, and the done state waits while the output is stalled.
// Reset (rst_n low, synchronous): all entries invalid, counters, byte totals and peak
// cleared, no result pending. Entry address and size storage is not cleared.
module allocation_tracking_table_unit
  import att_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  // Token links: link[0] is launched by the controller, link[i+1] leaves cell i.
  // The last link returns to the controller carrying match / claim status and
  // the old size of a matching entry.
  tok_t link [ENTRIES+1];
  cmt_t cmt;

  // Controller: hold the beat, launch the token, settle counters, drive the
  // output register and broadcast commit / cancel of a claimed free slot.
  att_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .tok_o     (link[0]),
    .tok_i     (link[ENTRIES]),
    .cmt_o     (cmt)
  );

  // Chain of table cells: the lowest matching cell acts first and marks the
  // token, so later cells stand aside; the lowest free cell claims the slot
  // tentatively and keeps it only if no match shows up further on.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    att_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (link[i]),
      .cmt_i (cmt),
      .tok_o (link[i+1])
    );
  end

endmodule

@@ hw/rtl/att_checker.sv @@
module att_checker
  import att_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall)
    else $error("input taken while a beat is in flight");

  a_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.accepted == ((out_data.outcome == OUT_UPDATED)
      || (out_data.outcome == OUT_NEW) || (out_data.outcome == OUT_RELEASED)))
    else $error("accepted flag disagrees with outcome");

  a_leaks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.leaks_present == (out_data.live_count != 7'd0))
    else $error("leak flag disagrees with live count");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.peak_live_bytes >= out_data.live_bytes)
    else $error("peak below live byte total");

endmodule

bind allocation_tracking_table_unit att_checker u_att_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
